@@ src/exchange_sort_asc_desc_defines.svh @@
// ----------------------------------------------------------------------------
// Exchange sort assertion macros
// Shared concurrent assertion forms for the exchange sort block.
// ----------------------------------------------------------------------------
`ifndef EXCHANGE_SORT_ASC_DESC_DEFINES_SVH
`define EXCHANGE_SORT_ASC_DESC_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ESAD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("esad assertion failed");

// Next-cycle implication, disabled during reset.
`define ESAD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("esad assertion failed");

`else

`define ESAD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define ESAD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

@@ src/esad_pkg.sv @@
// ----------------------------------------------------------------------------
// Exchange sort package
// Element type, transfer payloads and internal control structs.
// ----------------------------------------------------------------------------
package esad_pkg;

    // Element width and default store depth.
    localparam int VALUE_W              = 32;
    localparam int DEFAULT_MAX_ELEMENTS = 16;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Input transfer payload.
    typedef struct packed {
        value_t in_value;
        logic   in_last;
    } in_item_t;

    // Output transfer payload.
    typedef struct packed {
        value_t out_value;
        logic   out_last;
    } out_item_t;

    // Memory port strobes.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    // Operands of the exchange decision.
    typedef struct packed {
        value_t held;
        value_t cand;
        logic   desc;
    } cmp_in_t;

endpackage

@@ src/esad_mem.sv @@
// ----------------------------------------------------------------------------
// Exchange sort element store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module esad_mem #(
    parameter int DEPTH  = esad_pkg::DEFAULT_MAX_ELEMENTS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  esad_pkg::mem_ctl_t ctl,
    input  logic [ADDR_W-1:0] waddr,
    input  esad_pkg::value_t  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output esad_pkg::value_t  rdata
);
    import esad_pkg::*;

    value_t store_reg [DEPTH];
    value_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds between reads.
    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/esad_cmp.sv @@
// ----------------------------------------------------------------------------
// Exchange sort compare unit
// Decides whether the candidate element belongs before the held element.
// ----------------------------------------------------------------------------
module esad_cmp (
    input  esad_pkg::cmp_in_t op,
    output logic              swap
);
    import esad_pkg::*;

    // Signed compare in the direction chosen by the order register.
    always_comb
    begin
        if (op.desc)
        begin
            swap = (op.held < op.cand);
        end
        else
        begin
            swap = (op.cand < op.held);
        end
    end

endmodule

@@ src/exchange_sort_asc_desc.sv @@
// ----------------------------------------------------------------------------
// Exchange sort, ascending or descending: one input element per cycle while filling.
// Sort: each position in turn is held, compared with every later element, written back.
// Emit: the next result is read only once the last is taken; one element goes straight out.
// Reset (rst_n low, asynchronous) empties the set and selects ascending.
// ----------------------------------------------------------------------------
`include "exchange_sort_asc_desc_defines.svh"

module exchange_sort_asc_desc #(
    parameter int MAX_ELEMENTS = esad_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  esad_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output esad_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import esad_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [6:0] {
        S_FILL = 7'b0000001,
        S_LDI  = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_WRI  = 7'b0001000,
        S_ERD  = 7'b0010000,
        S_ECAP = 7'b0100000,
        S_EOUT = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    value_t     held_reg, held_next;
    logic       desc_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    mem_ctl_t   mem_ctl;
    logic [IDX_W-1:0] mem_waddr;
    value_t     mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    value_t     mem_rdata;
    cmp_in_t    cmp_op;
    logic       cmp_swap;
    logic       in_xfer;
    logic       out_xfer;
    logic       set_end;

    // Element store.
    esad_mem #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Exchange decision between the held element and the one just read.
    assign cmp_op.held = held_reg;
    assign cmp_op.cand = mem_rdata;
    assign cmp_op.desc = desc_reg;

    esad_cmp u_cmp (
        .op   (cmp_op),
        .swap (cmp_swap)
    );

    // Handshake decode.
    assign in_ready  = (state_reg == S_FILL);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;
    assign out_xfer  = out_valid_reg && out_ready;
    assign set_end   = in_item.in_last || (count_reg == CNT_W'(MAX_ELEMENTS - 1));

    // Order register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            desc_reg <= cfg_wdata;
        end
    end

    // Sequencer: fill, sort by read-compare-write, then emit (a set of one element skips the sort).
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_ctl.we     = 1'b0;
        mem_ctl.re     = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = in_item.in_value;
        mem_raddr      = '0;

        unique case (state_reg)
            S_FILL:
            begin
                if (in_xfer)
                begin
                    mem_ctl.we = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (set_end)
                    begin
                        n_next     = count_reg + CNT_W'(1);
                        count_next = '0;
                        i_next     = '0;
                        k_next     = '0;
                        if (count_reg == '0)
                        begin
                            // A set of one element goes straight out.
                            out_data_next.out_value = in_item.in_value;
                            out_data_next.out_last  = 1'b1;
                            out_valid_next          = 1'b1;
                            state_next              = S_EOUT;
                        end
                        else
                        begin
                            mem_ctl.re = 1'b1;
                            mem_raddr  = '0;
                            state_next = S_LDI;
                        end
                    end
                end
            end

            S_LDI:
            begin
                held_next  = mem_rdata;
                j_next     = i_reg + IDX_W'(1);
                mem_ctl.re = 1'b1;
                mem_raddr  = i_reg + IDX_W'(1);
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (cmp_swap)
                begin
                    mem_ctl.we = 1'b1;
                    mem_waddr  = j_reg;
                    mem_wdata  = held_reg;
                    held_next  = mem_rdata;
                end
                if ((CNT_W'(j_reg) + CNT_W'(1)) < n_reg)
                begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = j_reg + IDX_W'(1);
                    j_next     = j_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = S_WRI;
                end
            end

            S_WRI:
            begin
                mem_ctl.we = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = held_reg;
                if ((CNT_W'(i_reg) + CNT_W'(2)) < n_reg)
                begin
                    mem_ctl.re = 1'b1;
                    mem_raddr  = i_reg + IDX_W'(1);
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_LDI;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
            end

            S_ERD:
            begin
                mem_ctl.re = 1'b1;
                mem_raddr  = k_reg;
                state_next = S_ECAP;
            end

            S_ECAP:
            begin
                out_data_next.out_value = mem_rdata;
                out_data_next.out_last  = ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg);
                out_valid_next          = 1'b1;
                state_next              = S_EOUT;
            end

            S_EOUT:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    if (out_data_reg.out_last)
                    begin
                        count_next = '0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        mem_ctl.re = 1'b1;
                        mem_raddr  = k_reg + IDX_W'(1);
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_ECAP;
                    end
                end
            end

            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        held_reg     <= held_next;
        out_data_reg <= out_data_next;
    end

    // The block never takes input while a result is on offer.
    `ESAD_ASSERT_IMPLY(a_no_in_while_out, clk, rst_n, in_ready, !out_valid_reg)

    // The compared position always lies after the held position.
    `ESAD_ASSERT_IMPLY(a_j_after_i, clk, rst_n, state_reg == S_CMP, j_reg > i_reg)

    // An element that ends a set closes the input side at once.
    `ESAD_ASSERT_NEXT(a_set_end_closes, clk, rst_n, in_xfer && set_end, !in_ready)

    // The final result returns the block to an empty fill phase.
    `ESAD_ASSERT_NEXT(a_last_empties, clk, rst_n, out_xfer && out_data_reg.out_last,
        in_ready && (count_reg == '0))

endmodule

@@ test/sort_result_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted-output checker for the exchange sort block
// Watches the input, output and order-register ports. It keeps its own copy
// of the current set and the sort order, predicts each sorted set when the
// set closes, and compares every output transfer against the oldest
// prediction field by field.
// ----------------------------------------------------------------------------
module sort_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  esad_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_ready,
    input  esad_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output int                  fail_count,
    output int                  results_pending
);
    import esad_pkg::*;

    localparam int STORE_DEPTH = DEFAULT_MAX_ELEMENTS;

    // Elements of the set that is still open, and sorted results not yet seen.
    value_t    open_set[$];
    out_item_t sorted_results[$];
    logic      order_desc;

    // Order the closed set by pairwise exchange and queue one result per element.
    function automatic void close_set(logic desc);
        value_t    elems[$];
        value_t    held;
        out_item_t res;
        logic      swap;
        elems = open_set;
        for (int i = 0; i + 1 < elems.size(); i++)
        begin
            for (int j = i + 1; j < elems.size(); j++)
            begin
                swap = desc ? (elems[i] < elems[j]) : (elems[j] < elems[i]);
                if (swap)
                begin
                    held     = elems[i];
                    elems[i] = elems[j];
                    elems[j] = held;
                end
            end
        end
        foreach (elems[k])
        begin
            res.out_value = elems[k];
            res.out_last  = (k == elems.size() - 1);
            sorted_results.push_back(res);
        end
        open_set.delete();
    endfunction

    // Compare one output transfer with the oldest predicted result.
    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (sorted_results.size() == 0)
        begin
            $error("out_value %0d (out_last %0b) arrived with no result expected",
                   got.out_value, got.out_last);
            fail_count++;
            return;
        end
        want = sorted_results.pop_front();
        if (got.out_value !== want.out_value)
        begin
            $error("out_value mismatch: expected %0d, actual %0d",
                   want.out_value, got.out_value);
            fail_count++;
        end
        if (got.out_last !== want.out_last)
        begin
            $error("out_last mismatch: expected %0b, actual %0b",
                   want.out_last, got.out_last);
            fail_count++;
        end
    endfunction

    // Sample every channel on the rising edge. Results are checked before the
    // input transfer of the same edge is predicted, since they belong to an
    // earlier set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_set.delete();
            sorted_results.delete();
            order_desc      = 1'b0;
            fail_count      = 0;
            results_pending = 0;
        end
        else
        begin
            if (cfg_we)
                order_desc = cfg_wdata;
            if (out_valid && out_ready)
                check_result(out_item);
            if (in_valid && in_ready)
            begin
                open_set.push_back(in_item.in_value);
                // A set closes on the last flag or when the store fills up.
                if (in_item.in_last || open_set.size() == STORE_DEPTH)
                    close_set(order_desc);
            end
            results_pending = sorted_results.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Exchange sort testbench top
// Drives sets of signed elements into the sorter under several idle and
// stall patterns and both sort orders, with a long output hold-off that
// backs the block up. The checker beside the block does the prediction;
// this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import esad_pkg::*;

    localparam int STORE_DEPTH      = DEFAULT_MAX_ELEMENTS;
    localparam int SETTLE_CYCLES    = 40;
    localparam int RECV_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int PHASE_ITEMS      = 45;

    localparam value_t VALUE_MIN = 32'sh8000_0000;
    localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    logic      cfg_we;
    logic      cfg_wdata;

    int fail_count;
    int results_pending;

    // Idle and stall rates in percent, and output hold-off requests.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;

    exchange_sort_asc_desc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sort_result_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_item        (out_item),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // Clock with a period of 10.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        int served;
        served    = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (served != hold_requests)
            begin
                served++;
                out_ready <= 1'b0;
                repeat (RECV_HOLD_CYCLES) @(negedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one element, idling first at the current rate, and wait for the transfer.
    task automatic send_element(value_t value, logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_value: value, in_last: last};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop offering, wait for every sorted result, then let the block go quiet.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the sort order; only called while the block is idle.
    task automatic write_order(logic desc);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= desc;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random element: extremes and small clustered values give ties.
    function automatic value_t random_element();
        case ($urandom_range(9))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2, 3: return value_t'(int'($urandom_range(6)) - 3);
            default: return value_t'($urandom);
        endcase
    endfunction

    // Send one random set; returns the number of elements sent.
    task automatic send_random_set(output int sent);
        int   len;
        logic full_last;
        case ($urandom_range(19))
            0, 1, 2: len = STORE_DEPTH;
            3, 4, 5, 6, 7: len = $urandom_range(7, STORE_DEPTH - 1);
            default: len = $urandom_range(1, 6);
        endcase
        // A full store closes the set whatever the last flag says.
        full_last = 1'($urandom_range(1));
        for (int k = 0; k < len; k++)
        begin
            if (k == len - 1)
                send_element(random_element(), (len == STORE_DEPTH) ? full_last : 1'b1);
            else
                send_element(random_element(), 1'b0);
        end
        sent = len;
    endtask

    // One random phase at the given order and idle rates.
    task automatic run_phase(logic desc, int send_pct, int recv_pct, bit with_hold);
        int total;
        int sent;
        total = 0;
        write_order(desc);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (total < PHASE_ITEMS)
        begin
            send_random_set(sent);
            total += sent;
            // Hold the output off while sets keep coming, so the block backs up.
            if (with_hold && total == sent)
                hold_requests++;
        end
        settle();
    endtask

    // Reset, directed sets, then the random phases and the verdict.
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Ascending: a single element, then the field extremes.
        write_order(1'b0);
        send_element(value_t'(5), 1'b1);
        send_element(VALUE_MAX, 1'b0);
        send_element(VALUE_MIN, 1'b0);
        send_element(value_t'(0), 1'b0);
        send_element(value_t'(-1), 1'b0);
        send_element(value_t'(1), 1'b1);
        settle();

        // Descending: equal values, then a set closed by a full store.
        write_order(1'b1);
        send_element(value_t'(7), 1'b0);
        send_element(value_t'(7), 1'b0);
        send_element(value_t'(-7), 1'b0);
        send_element(value_t'(7), 1'b1);
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            if (k == 0)
                send_element(VALUE_MIN, 1'b0);
            else if (k == 5)
                send_element(VALUE_MAX, 1'b0);
            else if (k == 9)
                send_element(value_t'(32'sh5555_5555), 1'b0);
            else if (k == 12)
                send_element(value_t'(32'shAAAA_AAAA), 1'b0);
            else
                send_element(value_t'(k * 32'h9E37_79B9), 1'b0);
        end
        settle();

        // Random phases across idle patterns and both orders.
        run_phase(1'b0, 0, 0, 1'b1);
        run_phase(1'b1, 45, 0, 1'b0);
        run_phase(1'b0, 0, 45, 1'b0);
        run_phase(1'b1, 13, 13, 1'b0);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
